@@ rtl/core/hsc_pkg.sv @@
// hsc_pkg: beat types, register map and bit-placement helpers for the
// Hamming SEC codec. No dependencies; imported by hamming_sec_codec_core.
package hsc_pkg;

  localparam int WORD_W = 63;
  localparam int ERR_W  = 6;
  localparam int PAR_W  = 3;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register map, index = paddr[2]
  localparam logic REG_PARITY_COUNT = 1'b0;
  localparam logic [PAR_W-1:0] PARITY_RST = 3'd4;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] in_word;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic [ERR_W-1:0]  error_position;
  } out_beat_t;

  // Codeword mask for parity count p (saturated to 2..6).
  function automatic logic [WORD_W-1:0] cw_mask(input logic [PAR_W-1:0] p);
    logic [WORD_W-1:0] m;
    case (p) inside
      3'd0, 3'd1, 3'd2: m = 63'h7;
      3'd3:             m = 63'h7F;
      3'd4:             m = 63'h7FFF;
      3'd5:             m = 63'h7FFF_FFFF;
      default:          m = '1;
    endcase
    return m;
  endfunction

  // Data bits into the non-power-of-two positions, ascending. Fixed wiring.
  function automatic logic [WORD_W-1:0] spread(input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] r;
    int idx;
    r   = '0;
    idx = 0;
    for (int k = 1; k <= WORD_W; k++) begin
      if ((k & (k - 1)) != 0) begin
        r[k-1] = d[idx];
        idx++;
      end
    end
    return r;
  endfunction

  // Inverse of spread: pick the data positions back out, packed from bit 0.
  function automatic logic [WORD_W-1:0] gather(input logic [WORD_W-1:0] cw);
    logic [WORD_W-1:0] r;
    int idx;
    r   = '0;
    idx = 0;
    for (int k = 1; k <= WORD_W; k++) begin
      if ((k & (k - 1)) != 0) begin
        r[idx] = cw[k-1];
        idx++;
      end
    end
    return r;
  endfunction

  // Positions whose index has bit j set.
  function automatic logic [WORD_W-1:0] syn_mask(input int j);
    logic [WORD_W-1:0] m;
    for (int k = 1; k <= WORD_W; k++) begin
      m[k-1] = ((k >> j) & 1) != 0;
    end
    return m;
  endfunction

endpackage

@@ rtl/core/hamming_sec_codec_core.sv @@
// hamming_sec_codec_core: three-stage Hamming SEC encoder/decoder with an
// APB-style parity_count register. Depends on hsc_pkg.
//
//   channel   dir   handshake                 payload
//   in_       in    in_valid / in_ready       hsc_pkg::in_beat_t
//   out_      out   out_valid / out_ready     hsc_pkg::out_beat_t
//   apb       in    psel/penable/pwrite       paddr, pwdata, prdata
//
// One beat per cycle sustained while out_ready is held high. An accepted
// beat moves through the s1, s2 and output registers in turn (place/mask,
// syndrome XOR trees, correct/extract into the output register). Synchronous
// active-low reset empties the pipeline and sets parity_count to 4. A stalled
// output holds its beat; each stage refills as soon as the one after it
// moves, so nothing is dropped.
module hamming_sec_codec_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hsc_pkg::in_beat_t          in_beat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hsc_pkg::out_beat_t         out_beat,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hsc_pkg::ADDR_W-1:0] paddr,
  input  logic [hsc_pkg::DATA_W-1:0] pwdata,
  output logic [hsc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import hsc_pkg::*;

  logic [PAR_W-1:0]  parity_count_r;

  logic              s1_v_r, s1_cmd_r;
  logic [WORD_W-1:0] s1_cw_r, s1_cw_nxt;
  logic              s2_v_r, s2_cmd_r;
  logic [WORD_W-1:0] s2_cw_r;
  logic [ERR_W-1:0]  s2_syn_r, s2_syn_nxt;
  logic              out_v_r;
  out_beat_t         out_beat_r, out_beat_nxt;

  logic adv1, adv2, adv3;

  // ---------------- config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PARITY_COUNT) ? DATA_W'(parity_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_count_r <= PARITY_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PARITY_COUNT)) begin
      parity_count_r <= pwdata[PAR_W-1:0];
    end
  end

  // ---------------- stall chain
  assign adv3     = !out_v_r || out_ready;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  // stage 1: place data bits (encode) and trim to the code length
  always_comb begin
    if (in_beat.cmd == CMD_ENCODE) begin
      s1_cw_nxt = spread(in_beat.in_word) & cw_mask(parity_count_r);
    end else begin
      s1_cw_nxt = in_beat.in_word & cw_mask(parity_count_r);
    end
  end

  // stage 2: syndrome, one XOR tree per bit
  always_comb begin
    for (int j = 0; j < ERR_W; j++) begin
      s2_syn_nxt[j] = ^(s1_cw_r & syn_mask(j));
    end
  end

  // stage 3: insert parity, or flip the flagged position and extract data
  always_comb begin
    logic [WORD_W:0]   onehot;
    logic [WORD_W-1:0] enc;
    onehot = (WORD_W+1)'(1) << s2_syn_r;
    enc    = s2_cw_r;
    for (int j = 0; j < ERR_W; j++) begin
      enc[(1 << j) - 1] = s2_syn_r[j];
    end
    if (s2_cmd_r == CMD_ENCODE) begin
      out_beat_nxt.out_word       = enc;
      out_beat_nxt.error_position = '0;
    end else begin
      // zero syndrome gives an empty flip mask
      out_beat_nxt.out_word       = gather(s2_cw_r ^ onehot[WORD_W:1]);
      out_beat_nxt.error_position = s2_syn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r  <= in_valid;
      if (adv2) s2_v_r  <= s1_v_r;
      if (adv3) out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_cmd_r <= in_beat.cmd;
      s1_cw_r  <= s1_cw_nxt;
    end
    if (adv2 && s1_v_r) begin
      s2_cmd_r <= s1_cmd_r;
      s2_cw_r  <= s1_cw_r;
      s2_syn_r <= s2_syn_nxt;
    end
    if (adv3 && s2_v_r) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_beat  = out_beat_r;

endmodule

@@ verif/tb_hamming_sec_codec_core.sv @@
// tb_hamming_sec_codec_core: self-checking bench for the Hamming SEC codec core.
// Predicts encode/decode results at input accept and compares them in order at the output.
// Depends on hsc_pkg and hamming_sec_codec_core.
`timescale 1ns / 1ps

module tb_hamming_sec_codec_core;
  import hsc_pkg::*;

  localparam int MIN_PARITY   = 2;
  localparam int MAX_PARITY   = 6;
  localparam int ITEMS_PER_PH = 240;
  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE_CYC   = 8;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_beat_t            in_beat = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_beat_t           out_beat;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  in_beat_t            words_to_send[$];
  out_beat_t           codec_results_due[$];
  logic [PAR_W-1:0]    parity_setting = PARITY_RST;
  int                  send_idle_pct = 0;
  int                  ready_stall_pct = 0;
  int                  mismatches = 0;
  int                  quiet_cycles = 0;

  hamming_sec_codec_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  function automatic int code_length(logic [PAR_W-1:0] pc);
    int p;
    p = int'(pc);
    if (p < MIN_PARITY) p = MIN_PARITY;
    if (p > MAX_PARITY) p = MAX_PARITY;
    return (1 << p) - 1;
  endfunction

  function automatic logic [WORD_W-1:0] length_mask(int n);
    if (n >= WORD_W) return '1;
    return (63'(1) << n) - 63'(1);
  endfunction

  // XOR of the indices of all set positions
  function automatic logic [ERR_W-1:0] syndrome_of(logic [WORD_W-1:0] cw, int n);
    logic [ERR_W-1:0] s;
    s = '0;
    for (int k = 1; k <= n; k++) begin
      if (cw[k-1]) s ^= ERR_W'(k);
    end
    return s;
  endfunction

  function automatic out_beat_t codec_predict(in_beat_t b, logic [PAR_W-1:0] pc);
    out_beat_t         r;
    logic [WORD_W-1:0] cw;
    logic [ERR_W-1:0]  s;
    int                n;
    int                d;
    n = code_length(pc);
    r = '0;
    d = 0;
    if (b.cmd == CMD_ENCODE) begin
      for (int k = 1; k <= n; k++) begin
        if ((k & (k - 1)) != 0) begin
          r.out_word[k-1] = b.in_word[d];
          d++;
        end
      end
      s = syndrome_of(r.out_word, n);
      for (int j = 0; (1 << j) <= n; j++) begin
        if (s[j]) r.out_word[(1 << j) - 1] = 1'b1;
      end
    end else begin
      cw = b.in_word & length_mask(n);
      s  = syndrome_of(cw, n);
      if (s != '0) cw[s-1] = ~cw[s-1];
      for (int k = 1; k <= n; k++) begin
        if ((k & (k - 1)) != 0) begin
          r.out_word[d] = cw[k-1];
          d++;
        end
      end
      r.error_position = s;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'({$urandom, $urandom});
  endfunction

  // valid codeword for data under the current setting, one position flipped (0 = none)
  function automatic logic [WORD_W-1:0] codeword_hit(logic [WORD_W-1:0] data, int flip_pos);
    in_beat_t          b;
    logic [WORD_W-1:0] cw;
    b  = '{cmd: CMD_ENCODE, in_word: data};
    cw = codec_predict(b, parity_setting).out_word;
    if (flip_pos != 0) cw[flip_pos-1] = ~cw[flip_pos-1];
    return cw;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t          b;
    logic [WORD_W-1:0] cw;
    int                n;
    int                pick;
    n    = code_length(parity_setting);
    pick = $urandom_range(99);
    if (pick < 35) begin
      b = '{cmd: CMD_ENCODE, in_word: rand_word()};
    end else if (pick < 85) begin
      cw = codeword_hit(rand_word(), $urandom_range(n, 0));
      if ($urandom_range(3) == 0) cw |= rand_word() & ~length_mask(n);
      b = '{cmd: CMD_DECODE, in_word: cw};
    end else begin
      b = '{cmd: CMD_DECODE, in_word: rand_word()};
    end
    return b;
  endfunction

  task automatic send(logic cmd, logic [WORD_W-1:0] w);
    words_to_send.push_back(in_beat_t'{cmd: cmd, in_word: w});
  endtask

  task automatic drain();
    do @(posedge clk);
    while (words_to_send.size() != 0 || in_valid || codec_results_due.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // setup beat, access beat; the register takes the value at the access edge
  task automatic write_parity(logic [PAR_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PARITY_COUNT, 2'b00};
    pwdata  <= {(DATA_W-PAR_W)'($urandom_range(32'h1FFF_FFFF)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    parity_setting = value;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_beat  <= words_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: output checked before this edge's input beat is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (codec_results_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_beat);
        end else begin
          if (out_beat.out_word !== codec_results_due[0].out_word) begin
            mismatches++;
            $display("%0t: out_word mismatch, expected %h, actual %h", $time,
                     codec_results_due[0].out_word, out_beat.out_word);
          end
          if (out_beat.error_position !== codec_results_due[0].error_position) begin
            mismatches++;
            $display("%0t: error_position mismatch, expected %0d, actual %0d", $time,
                     codec_results_due[0].error_position, out_beat.error_position);
          end
          void'(codec_results_due.pop_front());
        end
      end
      if (in_valid && in_ready)
        codec_results_due.push_back(codec_predict(in_beat, parity_setting));
      out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // watchdog: no beat moving while work is outstanding
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (words_to_send.size() != 0 || in_valid || codec_results_due.size() != 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("hamming_sec_codec_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [PAR_W-1:0] settings[8];
    settings = '{3'd2, 3'd6, 3'd3, 3'd0, 3'd5, 3'd7, 3'd1, 3'd4};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset setting: 15-bit code
    send(CMD_ENCODE, '0);
    send(CMD_ENCODE, '1);
    send(CMD_ENCODE, 63'h7FF);
    send(CMD_DECODE, '0);
    send(CMD_DECODE, '1);
    send(CMD_DECODE, codeword_hit(63'h5A3, 0));
    send(CMD_DECODE, codeword_hit(63'h5A3, 1));
    send(CMD_DECODE, codeword_hit(63'h2C6, 8));
    send(CMD_DECODE, codeword_hit(63'h7FF, 3));
    send(CMD_DECODE, codeword_hit(63'h001, 15));
    send(CMD_DECODE, codeword_hit(63'h3B5, 6) | (rand_word() & ~length_mask(15)));
    drain();

    // directed, full 63-bit code
    write_parity(3'd6);
    send(CMD_ENCODE, '1);
    send(CMD_ENCODE, '0);
    send(CMD_DECODE, '1);
    send(CMD_DECODE, codeword_hit(rand_word(), 63));
    send(CMD_DECODE, codeword_hit(rand_word(), 32));
    send(CMD_DECODE, codeword_hit('1, 1));
    send(CMD_DECODE, codeword_hit('0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_parity(settings[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 65; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 65; end
        default: begin send_idle_pct = 24; ready_stall_pct = 24; end
      endcase
      for (int i = 0; i < ITEMS_PER_PH; i++) words_to_send.push_back(random_beat());
      drain();
    end

    if (codec_results_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected result beats never arrived", $time, codec_results_due.size());
    end
    if (mismatches == 0) begin
      $display("hamming_sec_codec_core verification clean");
    end else begin
      $display("hamming_sec_codec_core verification failed");
    end
    $finish;
  end

endmodule
